// File: hw/rtl/ade_pkg.sv
// Shared types, constants and fixed-point helpers of the adaptive dynamics estimator.
// Used by ade_mulr, ade_est_mem and the top level adaptive_dynamics_estimator.
package ade_pkg;

  localparam int unsigned NumEst   = 6;
  localparam int unsigned EstAw    = 3;
  localparam int unsigned MulAw    = 51;
  localparam int unsigned MulBw    = 34;
  localparam int unsigned MulRw    = 62;
  localparam logic [30:0] MassMin  = 31'd16777;

  typedef enum logic [2:0] {
    CFG_FILTER_COEF_LIN   = 3'd0,
    CFG_FILTER_COEF_ANG   = 3'd1,
    CFG_DEAD_ZONE_LIN     = 3'd2,
    CFG_DEAD_ZONE_ANG     = 3'd3,
    CFG_SURFACE_GAIN_LIN  = 3'd4,
    CFG_SURFACE_SLOPE_LIN = 3'd5,
    CFG_SURFACE_GAIN_ANG  = 3'd6,
    CFG_SURFACE_SLOPE_ANG = 3'd7
  } cfg_idx_e;

  // One request to the shared rounding multiplier.
  typedef struct packed {
    logic                     start;
    logic                     s32;
    logic signed [MulAw-1:0]  a;
    logic signed [MulBw-1:0]  b;
  } mul_req_t;

  localparam logic signed [47:0] NOMINAL [NumEst] = '{
    48'sd1039811582, 48'sd1199154869, -48'sd5583457,
    48'sd4295396793, 48'sd1174673555, 48'sd4092674336
  };
  localparam logic signed [MulBw-1:0] LEAK_Q32 [NumEst] = '{
    34'sd4294967, 34'sd429497, 34'sd429497, 34'sd429497, 34'sd4294967, 34'sd429497
  };
  localparam logic signed [MulBw-1:0] GAIN_Q32 [NumEst] = '{
    34'sd4294967, 34'sd85899346, 34'sd85899346, 34'sd42949673, 34'sd85899346,
    34'sd85899346
  };
  localparam logic [24:0] TANH_TAB [17] = '{
    25'd0, 25'd4109054, 25'd7753039, 25'd10656031, 25'd12777430, 25'd14231838,
    25'd15185868, 25'd15793661, 25'd16173699, 25'd16408555, 25'd16552641,
    25'd16640645, 25'd16694249, 25'd16726844, 25'd16746646, 25'd16758668,
    25'd16765964
  };
  localparam logic [24:0] EXP_TAB [17] = '{
    25'd16777216, 25'd10175897, 25'd6171993, 25'd3743503, 25'd2270549,
    25'd1377158, 25'd835288, 25'd506628, 25'd307285, 25'd186378, 25'd113044,
    25'd68565, 25'd41587, 25'd25224, 25'd15299, 25'd9279, 25'd5628
  };

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
    logic signed [47:0] r;
    if (x > 64'sd140737488355327) begin
      r = 48'sh7fffffffffff;
    end else if (x < -64'sd140737488355328) begin
      r = 48'sh800000000000;
    end else begin
      r = x[47:0];
    end
    return r;
  endfunction

  // Odd tanh from the table, step 0.25 in Q8.24, linear interpolation with floor.
  function automatic logic signed [25:0] tanh_q(input logic signed [39:0] x);
    logic [39:0] m;
    logic [3:0]  i;
    logic [24:0] lo;
    logic [24:0] diff;
    logic [46:0] prod;
    logic [25:0] v;
    m    = x[39] ? 40'(-x) : 40'(x);
    i    = m[25:22];
    lo   = TANH_TAB[i];
    diff = TANH_TAB[5'(i) + 5'd1] - lo;
    prod = 47'(diff) * 47'(m[21:0]);
    if (m[39:22] >= 18'd16) begin
      v = 26'(TANH_TAB[16]);
    end else begin
      v = 26'(lo) + 26'(prod[46:22]);
    end
    return x[39] ? -$signed(v) : $signed(v);
  endfunction

  // exp(-x) from the table, step 0.5 in Q8.24; the caller passes x = 2|y|.
  function automatic logic [24:0] exp_q(input logic [32:0] x);
    logic [3:0]          i;
    logic signed [25:0]  diff;
    logic signed [49:0]  prod;
    logic signed [26:0]  v;
    i    = x[26:23];
    diff = $signed({1'b0, EXP_TAB[5'(i) + 5'd1]}) - $signed({1'b0, EXP_TAB[i]});
    prod = 50'(diff) * $signed({1'b0, 49'(x[22:0])});
    v    = $signed(27'(EXP_TAB[i])) + 27'(prod >>> 23);
    if (x[32:23] >= 10'd16) begin
      return EXP_TAB[16];
    end
    return v[24:0];
  endfunction

endpackage

// File: hw/rtl/ade_mulr.sv
// Shared rounding multiplier: round(a*b / 2^s), half away from zero, s = 24 or 32.
// Low then high partial product, a registered result and done_o. Uses ade_pkg.
module ade_mulr (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ade_pkg::mul_req_t               req_i,
  output logic                            done_o,
  output logic signed [ade_pkg::MulRw-1:0] res_o
);
  import ade_pkg::*;

  logic [MulAw-1:0] ma_q;
  logic [MulBw-2:0] mb_q;
  logic             neg_q, s32_q;
  logic [57:0]      lo_q;
  logic [59:0]      hi_q;
  logic [60:0]      sum;
  logic [60:0]      mag;
  logic signed [MulRw-1:0] res_q;
  logic [3:0]       vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], req_i.start};
    end
  end

  assign sum = 61'(hi_q) + 61'(lo_q[57:24]);
  assign mag = s32_q ? (sum >> 8) : sum;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ma_q  <= req_i.a[MulAw-1] ? MulAw'(-req_i.a) : MulAw'(req_i.a);
      mb_q  <= req_i.b[MulBw-1] ? (MulBw-1)'(-req_i.b) : (MulBw-1)'(req_i.b);
      neg_q <= req_i.a[MulAw-1] ^ req_i.b[MulBw-1];
      s32_q <= req_i.s32;
    end
    if (vld_q[0]) begin
      lo_q <= 58'(ma_q[23:0]) * 58'(mb_q) + (s32_q ? (58'd1 << 31) : (58'd1 << 23));
    end
    if (vld_q[1]) begin
      hi_q <= 60'(ma_q[MulAw-1:24]) * 60'(mb_q);
    end
    if (vld_q[2]) begin
      res_q <= neg_q ? -$signed(MulRw'(mag)) : $signed(MulRw'(mag));
    end
  end

  assign done_o = vld_q[3];
  assign res_o  = res_q;

endmodule

// File: hw/rtl/ade_est_mem.sv
// Six-entry estimate store, one write and one registered read per cycle.
// Depends on ade_pkg for its depth and address width.
module ade_est_mem (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [ade_pkg::EstAw-1:0]      waddr_i,
  input  logic signed [47:0]             wdata_i,
  input  logic                           re_i,
  input  logic [ade_pkg::EstAw-1:0]      raddr_i,
  output logic signed [47:0]             rdata_o
);
  import ade_pkg::*;

  logic signed [47:0] mem [NumEst];
  logic signed [47:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/adaptive_dynamics_estimator.sv
// Adaptive dynamics estimator: sequencer, shared multiplier and estimate store.
// Depends on ade_pkg, ade_mulr and ade_est_mem.
//
// Input channel: one transfer per control tick with measured and reference
// velocities, two masses and the enable bit. If either mass is at or below
// 0.001 the transfer is taken while the block stays idle and gives no result.
// Otherwise the block works on that item alone and holds in_stall_o high until
// its result is handed to the output register.
// The fourteen front-end products run one after another on the one shared
// multiplier, with the two tanh steps, the two exp steps and the decision as
// table steps among them. Each of the six estimates then costs a store read
// plus three products with the update law running, or only the read without
// it. Once the result is in the output register the next input transfer can be
// taken in the following cycle; an item waits in S_FIN while the output
// register is full.
// Output channel: six estimates and was_updated sit in an output register that
// holds while out_stall_i is high; the next item can be taken meanwhile and
// finishes once the register is free.
// Reset returns configuration to defaults, estimates to nominal (valid bits
// cleared, no memory sweep) and the filter history to zero.
module adaptive_dynamics_estimator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [27:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] meas_lin_vel_i,
  input  logic signed [31:0] meas_ang_vel_i,
  input  logic signed [31:0] ref_lin_vel_i,
  input  logic signed [31:0] ref_ang_vel_i,
  input  logic [30:0]        lin_mass_i,
  input  logic [30:0]        ang_mass_i,
  input  logic               adapt_enable_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [47:0] est_p0_o,
  output logic signed [47:0] est_p1_o,
  output logic signed [47:0] est_p2_o,
  output logic signed [47:0] est_p3_o,
  output logic signed [47:0] est_p4_o,
  output logic signed [47:0] est_p5_o,
  output logic               was_updated_o
);
  import ade_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ISSUE = 6'b000010,
    S_WAIT  = 6'b000100,
    S_CALC  = 6'b001000,
    S_RDREQ = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  typedef enum logic [4:0] {
    OP_UF, OP_WF, OP_SLU, OP_TNU, OP_GU, OP_SLW, OP_TNW, OP_GW,
    OP_R0, OP_R1, OP_WW, OP_R2, OP_R3, OP_UW, OP_R4, OP_R5,
    OP_ATU, OP_ATW, OP_DEC, OP_LK, OP_T, OP_S
  } op_e;

  state_e state_q;
  op_e    op_q, op_nxt;

  // Configuration.
  logic [24:0] coef_lin_q, coef_ang_q;
  logic [27:0] dz_lin_q, dz_ang_q, gain_lin_q, slope_lin_q, gain_ang_q, slope_ang_q;

  // Persistent filter state.
  logic signed [31:0] prl_q, pra_q, fl_q, fa_q;
  logic               pen_q;
  logic [NumEst-1:0]  val_q;

  // Working registers of the current item.
  logic signed [31:0] u_q, w_q, ur_q, wr_q, ud_q, wd_q, uf_q, wf_q, ut_q, wt_q;
  logic signed [31:0] s1_q, s2_q, tmp_q;
  logic signed [31:0] r_q [NumEst];
  logic signed [39:0] tx_q;
  logic signed [25:0] th_q;
  logic [24:0]        atu_q, atw_q;
  logic               en_q, upd_q;
  logic [EstAw-1:0]   idx_q;
  logic signed [47:0] est_q;
  logic signed [49:0] leak_q, t_q;
  logic signed [47:0] work_q [NumEst];

  // Output register.
  logic               out_valid_q, out_upd_q;
  logic signed [47:0] out_est_q [NumEst];

  mul_req_t                 mul_req;
  logic                     mul_done;
  logic signed [MulRw-1:0]  mul_res;
  logic                     mem_we, mem_re;
  logic signed [47:0]       mem_rdata, est_new, est_c;

  logic                     in_acc, mass_ok, out_free, out_load;
  logic signed [63:0]       dl, da;
  logic signed [31:0]       uf_c, wf_c;
  logic [32:0]              aut, awt;

  ade_mulr u_mulr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  ade_est_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (idx_q),
    .wdata_i (est_new),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign mass_ok    = (lin_mass_i > MassMin) && (ang_mass_i > MassMin);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_FIN) && out_free;

  assign dl = 64'(ref_lin_vel_i) - 64'(prl_q);
  assign da = 64'(ref_ang_vel_i) - 64'(pra_q);

  assign uf_c = sat32(64'(fl_q) + 64'(mul_res));
  assign wf_c = sat32(64'(fa_q) + 64'(mul_res));
  assign aut  = ut_q[31] ? 33'(-64'(ut_q)) : 33'(ut_q);
  assign awt  = wt_q[31] ? 33'(-64'(wt_q)) : 33'(wt_q);

  // An entry that has not been written since the last restore reads as nominal.
  assign est_c   = val_q[idx_q] ? mem_rdata : NOMINAL[idx_q];
  assign est_new = sat48(64'(est_q) + 64'(mul_res));
  assign mem_we  = (state_q == S_WAIT) && mul_done && (op_q == OP_S);
  assign mem_re  = (state_q == S_RDREQ);

  assign op_nxt = op_e'(op_q + 5'd1);

  always_comb begin
    mul_req       = '0;
    mul_req.start = (state_q == S_ISSUE) && !((op_q == OP_LK) && !upd_q);
    case (op_q)
      OP_UF:   begin mul_req.a = 51'(ur_q) - 51'(fl_q); mul_req.b = {9'b0, coef_lin_q}; end
      OP_WF:   begin mul_req.a = 51'(wr_q) - 51'(fa_q); mul_req.b = {9'b0, coef_ang_q}; end
      OP_SLU:  begin mul_req.a = 51'(ut_q); mul_req.b = {6'b0, slope_lin_q}; end
      OP_GU:   begin mul_req.a = 51'(th_q); mul_req.b = {6'b0, gain_lin_q}; end
      OP_SLW:  begin mul_req.a = 51'(wt_q); mul_req.b = {6'b0, slope_ang_q}; end
      OP_GW:   begin mul_req.a = 51'(th_q); mul_req.b = {6'b0, gain_ang_q}; end
      OP_R0:   begin mul_req.a = 51'(s1_q); mul_req.b = 34'(ut_q); end
      OP_R1:   begin mul_req.a = 51'(s2_q); mul_req.b = 34'(wt_q); end
      OP_WW:   begin mul_req.a = 51'(w_q); mul_req.b = 34'(w_q); end
      OP_R2:   begin mul_req.a = 51'(tmp_q); mul_req.b = 34'(ut_q); end
      OP_R3:   begin mul_req.a = 51'(u_q); mul_req.b = 34'(ut_q); end
      OP_UW:   begin mul_req.a = 51'(u_q); mul_req.b = 34'(w_q); end
      OP_R4:   begin mul_req.a = 51'(tmp_q); mul_req.b = 34'(wt_q); end
      OP_R5:   begin mul_req.a = 51'(w_q); mul_req.b = 34'(wt_q); end
      OP_LK: begin
        mul_req.a   = 51'(est_c) - 51'(NOMINAL[idx_q]);
        mul_req.b   = LEAK_Q32[idx_q];
        mul_req.s32 = 1'b1;
      end
      OP_T: begin
        mul_req.a = (51'(r_q[idx_q]) <<< 8) - 51'(leak_q);
        mul_req.b = (idx_q < 3'd3) ? {9'b0, atu_q} : {9'b0, atw_q};
      end
      OP_S: begin
        mul_req.a   = 51'(t_q);
        mul_req.b   = GAIN_Q32[idx_q];
        mul_req.s32 = 1'b1;
      end
      default: begin
        mul_req.a = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_lin_q  <= 25'd645277;
      coef_ang_q  <= 25'd610081;
      dz_lin_q    <= 28'd687865;
      dz_ang_q    <= 28'd1090519;
      gain_lin_q  <= 28'd10066330;
      slope_lin_q <= 28'd13981013;
      gain_ang_q  <= 28'd24662508;
      slope_ang_q <= 28'd22826144;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_FILTER_COEF_LIN:   coef_lin_q  <= cfg_wdata_i[24:0];
        CFG_FILTER_COEF_ANG:   coef_ang_q  <= cfg_wdata_i[24:0];
        CFG_DEAD_ZONE_LIN:     dz_lin_q    <= cfg_wdata_i;
        CFG_DEAD_ZONE_ANG:     dz_ang_q    <= cfg_wdata_i;
        CFG_SURFACE_GAIN_LIN:  gain_lin_q  <= cfg_wdata_i;
        CFG_SURFACE_SLOPE_LIN: slope_lin_q <= cfg_wdata_i;
        CFG_SURFACE_GAIN_ANG:  gain_ang_q  <= cfg_wdata_i;
        CFG_SURFACE_SLOPE_ANG: slope_ang_q <= cfg_wdata_i;
        default:               coef_lin_q  <= coef_lin_q;
      endcase
    end
  end

  // Control state and persistent filter history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_UF;
      idx_q       <= '0;
      upd_q       <= 1'b0;
      val_q       <= '0;
      pen_q       <= 1'b0;
      prl_q       <= '0;
      pra_q       <= '0;
      fl_q        <= '0;
      fa_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && mass_ok) begin
            op_q    <= OP_UF;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if ((op_q == OP_LK) && !upd_q) begin
            if (idx_q == 3'(NumEst - 1)) begin
              state_q <= S_FIN;
            end else begin
              idx_q   <= idx_q + 3'd1;
              state_q <= S_RDREQ;
            end
          end else begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mul_done) begin
            if (op_q == OP_S) begin
              val_q[idx_q] <= 1'b1;
              op_q         <= OP_LK;
              if (idx_q == 3'(NumEst - 1)) begin
                state_q <= S_FIN;
              end else begin
                idx_q   <= idx_q + 3'd1;
                state_q <= S_RDREQ;
              end
            end else begin
              op_q    <= op_nxt;
              state_q <= (op_nxt inside {OP_TNU, OP_TNW, OP_ATU}) ? S_CALC : S_ISSUE;
            end
          end
        end
        S_CALC: begin
          if (op_q == OP_DEC) begin
            if (!en_q || !pen_q) begin
              val_q <= '0;
            end
            upd_q   <= en_q && ((aut > 33'(dz_lin_q)) || (awt > 33'(dz_ang_q)));
            pen_q   <= en_q;
            prl_q   <= ur_q;
            pra_q   <= wr_q;
            fl_q    <= uf_q;
            fa_q    <= wf_q;
            idx_q   <= '0;
            op_q    <= OP_LK;
            state_q <= S_RDREQ;
          end else begin
            op_q    <= op_nxt;
            state_q <= (op_nxt inside {OP_ATW, OP_DEC}) ? S_CALC : S_ISSUE;
          end
        end
        S_RDREQ: begin
          state_q <= S_ISSUE;
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the current item.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      u_q  <= meas_lin_vel_i;
      w_q  <= meas_ang_vel_i;
      ur_q <= ref_lin_vel_i;
      wr_q <= ref_ang_vel_i;
      en_q <= adapt_enable_i;
      ud_q <= sat32((dl <<< 6) + (dl <<< 5) + (dl <<< 2));
      wd_q <= sat32((da <<< 6) + (da <<< 5) + (da <<< 2));
    end
    if ((state_q == S_ISSUE) && (op_q == OP_LK)) begin
      est_q <= est_c;
      if (!upd_q) begin
        work_q[idx_q] <= est_c;
      end
    end
    if ((state_q == S_WAIT) && mul_done) begin
      case (op_q)
        OP_UF:  begin uf_q <= uf_c; ut_q <= sat32(64'(uf_c) - 64'(u_q)); end
        OP_WF:  begin wf_q <= wf_c; wt_q <= sat32(64'(wf_c) - 64'(w_q)); end
        OP_SLU: tx_q <= mul_res[39:0];
        OP_SLW: tx_q <= mul_res[39:0];
        OP_GU:  s1_q <= sat32(64'(ud_q) + 64'(mul_res));
        OP_GW:  s2_q <= sat32(64'(wd_q) + 64'(mul_res));
        OP_R0:  r_q[0] <= sat32(64'(mul_res));
        OP_R1:  r_q[1] <= sat32(64'(mul_res));
        OP_WW:  tmp_q <= sat32(64'(mul_res));
        OP_R2:  r_q[2] <= sat32(-64'(sat32(64'(mul_res))));
        OP_R3:  r_q[3] <= sat32(64'(mul_res));
        OP_UW:  tmp_q <= sat32(64'(mul_res));
        OP_R4:  r_q[4] <= sat32(64'(mul_res));
        OP_R5:  r_q[5] <= sat32(64'(mul_res));
        OP_LK:  leak_q <= mul_res[49:0];
        OP_T:   t_q <= mul_res[49:0];
        OP_S:   work_q[idx_q] <= est_new;
        default: tmp_q <= tmp_q;
      endcase
    end
    if (state_q == S_CALC) begin
      case (op_q)
        OP_TNU:  th_q <= tanh_q(tx_q);
        OP_TNW:  th_q <= tanh_q(tx_q);
        OP_ATU:  atu_q <= exp_q(ud_q[31] ? 33'(-64'(ud_q)) << 1 : 33'(ud_q) << 1);
        OP_ATW:  atw_q <= exp_q(wd_q[31] ? 33'(-64'(wd_q)) << 1 : 33'(wd_q) << 1);
        default: th_q <= th_q;
      endcase
    end
    if (out_load) begin
      out_est_q <= work_q;
      out_upd_q <= upd_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign est_p0_o      = out_est_q[0];
  assign est_p1_o      = out_est_q[1];
  assign est_p2_o      = out_est_q[2];
  assign est_p3_o      = out_est_q[3];
  assign est_p4_o      = out_est_q[4];
  assign est_p5_o      = out_est_q[5];
  assign was_updated_o = out_upd_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_WAIT))
    else $error("multiplier result arrived outside a wait step");

  a_write_only_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> upd_q)
    else $error("estimate store written without an active update");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (idx_q < 3'(NumEst)))
    else $error("estimate index out of range");

  a_calc_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC) |-> ((op_q == OP_TNU) || (op_q == OP_TNW) || (op_q == OP_ATU) ||
                             (op_q == OP_ATW) || (op_q == OP_DEC)))
    else $error("multiplier operation reached the table step");

endmodule

// File: dv/ade_scoreboard.sv
// Checker for the adaptive dynamics estimator: tracks register writes, predicts each
// tick's estimates from accepted input transfers and compares output transfers.
// Depends on ade_pkg for the register index enum and the fixed-point tables.
module ade_scoreboard (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [27:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] meas_lin_vel_i,
  input  logic signed [31:0] meas_ang_vel_i,
  input  logic signed [31:0] ref_lin_vel_i,
  input  logic signed [31:0] ref_ang_vel_i,
  input  logic [30:0]        lin_mass_i,
  input  logic [30:0]        ang_mass_i,
  input  logic               adapt_enable_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [47:0] est_p0_i,
  input  logic signed [47:0] est_p1_i,
  input  logic signed [47:0] est_p2_i,
  input  logic signed [47:0] est_p3_i,
  input  logic signed [47:0] est_p4_i,
  input  logic signed [47:0] est_p5_i,
  input  logic               was_updated_i,
  output int unsigned        mismatches_o,
  output int unsigned        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ade_pkg::*;

  typedef struct packed {
    logic [5:0][47:0] est;
    logic             updated;
  } tick_result_t;

  tick_result_t expected_ticks[$];

  longint coef_lin, coef_ang, dz_lin, dz_ang;
  longint gain_lin, slope_lin, gain_ang, slope_ang;
  longint est_q[6];
  longint last_ref_lin, last_ref_ang, filt_lin, filt_ang;
  bit     last_enable;

  function automatic longint clip(longint x, int n);
    longint lim;
    lim = longint'(1) <<< (n - 1);
    if (x >= lim) return lim - 1;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic longint mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  // Rounded product, half away from zero, formed on magnitudes.
  function automatic longint round_mul(longint a, longint b, int s);
    logic [63:0] ma, mb, hi, lo, r;
    ma = 64'(mag(a));
    mb = 64'(mag(b));
    hi = (ma >> 24) * mb;
    lo = (ma & 64'hFFFFFF) * mb + (64'd1 << (s - 1));
    r  = (hi + (lo >> 24)) >> (s - 24);
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint table_lookup(bit use_exp, longint x, int sh);
    longint idx, frac, lo, hi;
    idx = x >>> sh;
    if (idx >= 16) return use_exp ? longint'(EXP_TAB[16]) : longint'(TANH_TAB[16]);
    frac = x & ((longint'(1) <<< sh) - 1);
    lo = use_exp ? longint'(EXP_TAB[idx]) : longint'(TANH_TAB[idx]);
    hi = use_exp ? longint'(EXP_TAB[idx + 1]) : longint'(TANH_TAB[idx + 1]);
    return lo + (((hi - lo) * frac) >>> sh);
  endfunction

  function automatic longint soft_sign(longint x);
    longint v;
    v = table_lookup(1'b0, mag(x), 22);
    return x < 0 ? -v : v;
  endfunction

  function automatic longint mul_q24(longint a, longint b);
    return clip(round_mul(a, b, 24), 32);
  endfunction

  task automatic load_nominal();
    for (int i = 0; i < 6; i++) est_q[i] = longint'(NOMINAL[i]);
  endtask

  task automatic predict_tick();
    longint u, w, ur, wr, ud, wd, uf, wf, ut, wt, s1, s2, att_u, att_w;
    longint leak, drive, scaled;
    longint reg_term[6];
    bit upd;
    tick_result_t res;
    u  = meas_lin_vel_i;
    w  = meas_ang_vel_i;
    ur = ref_lin_vel_i;
    wr = ref_ang_vel_i;
    upd = 1'b0;
    // A small mass marks a tick that is dropped without touching any state.
    if (lin_mass_i <= MassMin || ang_mass_i <= MassMin) return;
    ud = clip((ur - last_ref_lin) * 100, 32);
    wd = clip((wr - last_ref_ang) * 100, 32);
    uf = clip(filt_lin + round_mul(ur - filt_lin, coef_lin, 24), 32);
    wf = clip(filt_ang + round_mul(wr - filt_ang, coef_ang, 24), 32);
    ut = clip(uf - u, 32);
    wt = clip(wf - w, 32);
    s1 = clip(ud + round_mul(soft_sign(round_mul(ut, slope_lin, 24)), gain_lin, 24), 32);
    s2 = clip(wd + round_mul(soft_sign(round_mul(wt, slope_ang, 24)), gain_ang, 24), 32);
    reg_term[0] = mul_q24(s1, ut);
    reg_term[1] = mul_q24(s2, wt);
    reg_term[2] = clip(-mul_q24(mul_q24(w, w), ut), 32);
    reg_term[3] = mul_q24(u, ut);
    reg_term[4] = mul_q24(mul_q24(u, w), wt);
    reg_term[5] = mul_q24(w, wt);
    if (adapt_enable_i) begin
      if (!last_enable) load_nominal();
      if (mag(ut) > dz_lin || mag(wt) > dz_ang) begin
        att_u = table_lookup(1'b1, 2 * mag(ud), 23);
        att_w = table_lookup(1'b1, 2 * mag(wd), 23);
        for (int i = 0; i < 6; i++) begin
          leak   = round_mul(est_q[i] - longint'(NOMINAL[i]), longint'(LEAK_Q32[i]), 32);
          drive  = reg_term[i] * 256 - leak;
          scaled = round_mul(drive, i < 3 ? att_u : att_w, 24);
          est_q[i] = clip(est_q[i] + round_mul(scaled, longint'(GAIN_Q32[i]), 32), 48);
        end
        upd = 1'b1;
      end
    end else begin
      load_nominal();
    end
    last_enable  = adapt_enable_i;
    last_ref_lin = ur;
    last_ref_ang = wr;
    filt_lin     = uf;
    filt_ang     = wf;
    for (int i = 0; i < 6; i++) res.est[i] = est_q[i][47:0];
    res.updated = upd;
    expected_ticks = {expected_ticks, res};
  endtask

  task automatic check_result();
    tick_result_t exp_r;
    logic [5:0][47:0] got;
    got = {est_p5_i, est_p4_i, est_p3_i, est_p2_i, est_p1_i, est_p0_i};
    if (expected_ticks.size() == 0) begin
      $display("%0t: unexpected output transfer, est_p0 %0d", $realtime, est_p0_i);
      mismatches_o++;
      return;
    end
    exp_r = expected_ticks.pop_front();
    for (int i = 0; i < 6; i++) begin
      if (got[i] !== exp_r.est[i]) begin
        $display("%0t: est_p%0d expected %0d actual %0d", $realtime, i,
                 $signed(exp_r.est[i]), $signed(got[i]));
        mismatches_o++;
      end
    end
    if (was_updated_i !== exp_r.updated) begin
      $display("%0t: was_updated expected %0b actual %0b", $realtime, exp_r.updated,
               was_updated_i);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_lin = 645277;    coef_ang = 610081;
      dz_lin = 687865;      dz_ang = 1090519;
      gain_lin = 10066330;  slope_lin = 13981013;
      gain_ang = 24662508;  slope_ang = 22826144;
      load_nominal();
      last_ref_lin = 0; last_ref_ang = 0;
      filt_lin = 0;     filt_ang = 0;
      last_enable = 1'b0;
      expected_ticks.delete();
      mismatches_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_FILTER_COEF_LIN:   coef_lin  = longint'(cfg_wdata_i[24:0]);
          CFG_FILTER_COEF_ANG:   coef_ang  = longint'(cfg_wdata_i[24:0]);
          CFG_DEAD_ZONE_LIN:     dz_lin    = longint'(cfg_wdata_i);
          CFG_DEAD_ZONE_ANG:     dz_ang    = longint'(cfg_wdata_i);
          CFG_SURFACE_GAIN_LIN:  gain_lin  = longint'(cfg_wdata_i);
          CFG_SURFACE_SLOPE_LIN: slope_lin = longint'(cfg_wdata_i);
          CFG_SURFACE_GAIN_ANG:  gain_ang  = longint'(cfg_wdata_i);
          CFG_SURFACE_SLOPE_ANG: slope_ang = longint'(cfg_wdata_i);
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) predict_tick();
      pending_o = expected_ticks.size();
    end
  end

endmodule

// File: dv/tb_adaptive_dynamics_estimator.sv
// Top of the estimator testbench: clock, reset, register writes and tick stimulus
// under several idle/stall mixes. Depends on ade_pkg, the block and ade_scoreboard.
module tb_adaptive_dynamics_estimator;
  timeunit 1ns;
  timeprecision 1ps;
  import ade_pkg::*;

  localparam int unsigned HangLimit = 40000;
  localparam int unsigned DrainCycles = 250;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_addr = '0;
  logic [27:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] meas_lin = '0, meas_ang = '0, ref_lin = '0, ref_ang = '0;
  logic [30:0]        lin_mass = '0, ang_mass = '0;
  logic               enable = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [47:0] est_p0, est_p1, est_p2, est_p3, est_p4, est_p5;
  logic               was_updated;
  int unsigned        mismatches, pending;
  int unsigned        idle_mode = 0;
  int unsigned        quiet_cycles = 0;
  bit                 sticky_enable = 1'b1;

  adaptive_dynamics_estimator dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .meas_lin_vel_i(meas_lin), .meas_ang_vel_i(meas_ang),
    .ref_lin_vel_i(ref_lin), .ref_ang_vel_i(ref_ang),
    .lin_mass_i(lin_mass), .ang_mass_i(ang_mass), .adapt_enable_i(enable),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .est_p0_o(est_p0), .est_p1_o(est_p1), .est_p2_o(est_p2),
    .est_p3_o(est_p3), .est_p4_o(est_p4), .est_p5_o(est_p5),
    .was_updated_o(was_updated)
  );

  ade_scoreboard checker_i (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .meas_lin_vel_i(meas_lin), .meas_ang_vel_i(meas_ang),
    .ref_lin_vel_i(ref_lin), .ref_ang_vel_i(ref_ang),
    .lin_mass_i(lin_mass), .ang_mass_i(ang_mass), .adapt_enable_i(enable),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .est_p0_i(est_p0), .est_p1_i(est_p1), .est_p2_i(est_p2),
    .est_p3_i(est_p3), .est_p4_i(est_p4), .est_p5_i(est_p5),
    .was_updated_i(was_updated),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Idle modes: 0 none, 1 sender idles often, 2 receiver stalls often, 3 both rarely.
  function automatic bit roll_idle(bit receiver);
    case (idle_mode)
      1: return !receiver && $urandom_range(0, 99) < 67;
      2: return receiver && $urandom_range(0, 99) < 67;
      3: return $urandom_range(0, 99) < 8;
      default: return 1'b0;
    endcase
  endfunction

  always @(negedge clk_i) out_stall <= roll_idle(1'b1);

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HangLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [27:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic write_all(logic [27:0] c_lin, logic [27:0] c_ang, logic [27:0] dzl,
                           logic [27:0] dza, logic [27:0] gl, logic [27:0] sl,
                           logic [27:0] ga, logic [27:0] sa);
    write_reg(CFG_FILTER_COEF_LIN, c_lin);
    write_reg(CFG_FILTER_COEF_ANG, c_ang);
    write_reg(CFG_DEAD_ZONE_LIN, dzl);
    write_reg(CFG_DEAD_ZONE_ANG, dza);
    write_reg(CFG_SURFACE_GAIN_LIN, gl);
    write_reg(CFG_SURFACE_SLOPE_LIN, sl);
    write_reg(CFG_SURFACE_GAIN_ANG, ga);
    write_reg(CFG_SURFACE_SLOPE_ANG, sa);
  endtask

  // Drop in_valid, wait for every expected result, then let the clock run on idle.
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_tick(logic signed [31:0] ul, logic signed [31:0] wl,
                           logic signed [31:0] ur, logic signed [31:0] wr,
                           logic [30:0] ml, logic [30:0] ma, logic en);
    bit taken;
    while (roll_idle(1'b0)) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    meas_lin = ul; meas_ang = wl; ref_lin = ur; ref_ang = wr;
    lin_mass = ml; ang_mass = ma; enable = en;
    do begin
      taken = !in_stall;
      @(negedge clk_i);
    end while (!taken);
  endtask

  function automatic logic signed [31:0] rand_vel();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1, 2:    return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      3:       return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      4:       return $signed($urandom_range(0, 1 << 28)) - (1 << 27);
      default: return 0;
    endcase
  endfunction

  function automatic logic [30:0] rand_mass();
    if ($urandom_range(0, 99) < 4) return 31'($urandom_range(0, 16777));
    if ($urandom_range(0, 3) == 0) return 31'($urandom);
    return 31'($urandom_range(16778, 1 << 26));
  endfunction

  task automatic send_random(int unsigned count);
    logic signed [31:0] rl, ra;
    rl = 0;
    ra = 0;
    repeat (count) begin
      if ($urandom_range(0, 99) < 5) sticky_enable = !sticky_enable;
      // Mostly slowly moving references so the filter and derivative paths stay sane.
      if ($urandom_range(0, 9) == 0) begin
        rl = rand_vel();
        ra = rand_vel();
      end else begin
        rl = rl + $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        ra = ra + $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      end
      send_tick(rand_vel(), rand_vel(), rl, ra, rand_mass(), rand_mass(), sticky_enable);
    end
  endtask

  initial begin
    logic signed [31:0] vmax, vmin;
    logic [30:0]        one;
    vmax = 32'sh7fffffff;
    vmin = 32'sh80000000;
    one  = 31'd16777216;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed ticks under reset register values.
    send_tick(0, 0, 0, 0, one, one, 1'b0);
    send_tick(0, 0, 0, 0, one, one, 1'b1);
    send_tick(1 << 20, 0, 1 << 24, 0, 31'd16777, one, 1'b1);
    send_tick(1 << 20, 0, 1 << 24, 0, one, 31'd16777, 1'b1);
    send_tick(1 << 20, 0, 1 << 24, 0, 31'd0, 31'd0, 1'b1);
    send_tick(1 << 20, 1 << 19, 1 << 24, 1 << 23, 31'd16778, 31'd16778, 1'b1);
    send_tick(vmax, vmax, vmin, vmin, 31'h7fffffff, 31'h7fffffff, 1'b1);
    send_tick(vmin, vmin, vmax, vmax, one, one, 1'b1);
    send_tick(vmax, vmin, vmin, vmax, one, one, 1'b1);
    send_tick(-1, -1, -1, -1, one, one, 1'b0);
    send_tick(1 << 24, -(1 << 24), 1 << 23, 1 << 22, one, one, 1'b1);
    send_tick(-(1 << 22), 1 << 22, 1 << 23, 1 << 22, one, one, 1'b1);
    send_tick(100, -100, 200, -200, one, one, 1'b1);
    send_tick(1 << 26, -(1 << 26), 0, 0, one, one, 1'b1);
    send_tick(0, 0, 5 << 24, -(5 << 24), one, one, 1'b1);
    drain();

    write_all(28'd16777216, 28'd16777216, 28'hfffffff, 28'hfffffff,
              28'hfffffff, 28'hfffffff, 28'hfffffff, 28'hfffffff);
    send_tick(vmax, vmin, 1 << 24, -(1 << 24), one, one, 1'b1);
    send_tick(1 << 24, 1 << 24, 0, 0, one, one, 1'b1);
    drain();
    write_all(28'd0, 28'd0, 28'd0, 28'd0, 28'd0, 28'd0, 28'd0, 28'd0);
    send_tick(1 << 24, -(1 << 24), 1 << 22, 1 << 21, one, one, 1'b1);
    send_tick(vmin, vmax, vmax, vmin, one, one, 1'b1);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      idle_mode = phase % 4;
      case (phase)
        0: write_all(28'd645277, 28'd610081, 28'd687865, 28'd1090519,
                     28'd10066330, 28'd13981013, 28'd24662508, 28'd22826144);
        1: write_all(28'd16777216, 28'd0, 28'd0, 28'hfffffff,
                     28'hfffffff, 28'd0, 28'd0, 28'hfffffff);
        2: write_all(28'h1ffffff, 28'h1ffffff, 28'd100, 28'd100,
                     28'd1 << 24, 28'd1 << 24, 28'd1 << 24, 28'd1 << 24);
        default: write_all(28'($urandom), 28'($urandom), 28'($urandom_range(0, 1 << 22)),
                           28'($urandom_range(0, 1 << 22)), 28'($urandom),
                           28'($urandom), 28'($urandom), 28'($urandom));
      endcase
      send_random(300);
      drain();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
